### design/prbf_pkg.sv
// Package for the packet ring byte FIFO.
// Holds the item structs, opcode and status codes, FSM state type and the
// command and status structs shared by the controller and the datapath.
package prbf_pkg;

	typedef enum logic [2:0] {
		OP_REWIND   = 3'd0,
		OP_SEND     = 3'd1,
		OP_RECV     = 3'd2,
		OP_PEEK     = 3'd3,
		OP_PKT_CHK  = 3'd4,
		OP_PKT_RECV = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_NOROOM = 2'd2,
		ST_SMALL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CNT_ZERO = 2'd0,
		CNT_SEND = 2'd1,
		CNT_N    = 2'd2,
		CNT_SIZE = 2'd3
	} cnt_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SEND_WR,
		S_PK_0,
		S_PK_1,
		S_PK_2,
		S_PK_3,
		S_RD_ISSUE,
		S_RD_EMIT,
		S_EMIT1
	} state_t;

	// Largest send in bytes.
	localparam int unsigned MAX_SEND = 8;
	// Results one item may produce.
	localparam int unsigned MAX_RESULTS = 32;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  length;
		logic [63:0] send_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  count;
		logic [63:0] data_word;
		logic [3:0]  word_bytes;
		logic        last;
		logic [7:0]  fill_level;
		logic [7:0]  free_space;
	} out_item_t;

	typedef struct packed {
		logic     accept;
		logic     rewind;
		logic     send_start;
		logic     wr_byte;
		logic     rd_start;
		logic     rd_issue;
		logic     pk_issue;
		logic     cap_lo;
		logic     cap_hi;
		logic     emit;
		logic     emit_data;
		status_t  status;
		cnt_sel_t cnt_sel;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       fill_zero;
		logic       fill_lt2;
		logic       room;
		logic       len_zero;
		logic       n_zero;
		logic       size_gt_fill;
		logic       size_big;
		logic       left_one;
		logic       left_zero;
		logic       can_issue;
		logic       out_free;
	} sts_t;

endpackage

### design/prbf_req_if.sv
// Input item channel of the packet ring byte FIFO.
// Depends on prbf_pkg for the payload struct.
interface prbf_req_if;
	logic               valid;
	logic               ready;
	prbf_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/prbf_rsp_if.sv
// Result item channel of the packet ring byte FIFO.
// Depends on prbf_pkg for the payload struct.
interface prbf_rsp_if;
	logic                valid;
	logic                ready;
	prbf_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/prbf_cfg_if.sv
// Configuration write channel of the packet ring byte FIFO.
// Carries the size_log2 register value; no dependencies.
interface prbf_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/prbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module prbf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### design/prbf_dp.sv
// Datapath of the packet ring byte FIFO: pointers, byte store, word packing
// and the result register. Depends on prbf_pkg and prbf_ram.
module prbf_dp #(
	parameter int unsigned CAPACITY       = 256,
	parameter int unsigned BYTES_PER_WORD = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  prbf_pkg::cmd_t      cmd,
	output prbf_pkg::sts_t      sts,
	input  prbf_pkg::in_item_t  in_data,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output prbf_pkg::out_item_t out_data
);
	import prbf_pkg::*;

	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned FLOG = $clog2(CAPACITY + 1) - 1;
	localparam int unsigned LIM  = (FLOG < 8) ? FLOG : 8;
	localparam int unsigned WW   = BYTES_PER_WORD * 8;
	localparam int unsigned SW   = $clog2(BYTES_PER_WORD + 1);
	localparam int unsigned MAX_READ = MAX_RESULTS * BYTES_PER_WORD;

	logic [3:0]    size_log2_q;
	logic [7:0]    read_pos_q, write_pos_q;
	logic [7:0]    rd_addr_q, wr_addr_q;
	logic [2:0]    op_q;
	logic [7:0]    len_q;
	logic [63:0]   data_q;
	logic [7:0]    n_q, left_q;
	logic [15:0]   size_q;
	logic [SW-1:0] slot_q, cap_slot_q;
	logic          pend_q;
	logic [WW-1:0] word_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic [3:0]  s_eff;
	logic [7:0]  mask, fill, free_b, len_c8, limit, n_next;
	logic [3:0]  len_c;
	logic [8:0]  n_a;
	logic [7:0]  rdata;
	logic [AW+7:0] waddr_ext, raddr_ext;
	logic        out_free;
	logic [7:0]  cnt;

	// Effective ring size and occupancy.
	always_comb begin
		s_eff = size_log2_q;
		if (s_eff < 4'd1) begin
			s_eff = 4'd1;
		end
		if (s_eff > 4'(LIM)) begin
			s_eff = 4'(LIM);
		end
		mask   = 8'((9'd1 << s_eff) - 9'd1);
		fill   = (write_pos_q - read_pos_q) & mask;
		free_b = (read_pos_q - write_pos_q - 8'd1) & mask;
	end

	// Clamped send length and read byte count.
	always_comb begin
		len_c  = (len_q > 8'(MAX_SEND)) ? 4'(MAX_SEND) : len_q[3:0];
		len_c8 = {4'd0, len_c};
		limit  = (op_q == OP_PKT_RECV) ? size_q[7:0] : len_q;
		n_a    = {1'b0, (fill < limit) ? fill : limit};
		if (n_a > 9'(MAX_READ)) begin
			n_a = 9'(MAX_READ);
		end
		n_next = n_a[7:0];
	end

	assign out_free = !out_valid_q || out_ready;

	// Status toward the controller.
	always_comb begin
		sts.op           = op_q;
		sts.fill_zero    = (fill == 8'd0);
		sts.fill_lt2     = (fill < 8'd2);
		sts.room         = (free_b >= len_c8);
		sts.len_zero     = (len_c == 4'd0);
		sts.n_zero       = (n_next == 8'd0);
		sts.size_gt_fill = (size_q > {8'd0, fill});
		sts.size_big     = (size_q > {8'd0, len_q}) || (size_q > 16'(MAX_READ));
		sts.left_one     = (left_q == 8'd1);
		sts.left_zero    = (left_q == 8'd0);
		sts.can_issue    = (left_q != 8'd0) && (slot_q < SW'(BYTES_PER_WORD));
		sts.out_free     = out_free;
	end

	// Byte store addresses from ring pointers.
	assign waddr_ext = {{AW{1'b0}}, wr_addr_q};
	assign raddr_ext = {{AW{1'b0}}, rd_addr_q};

	prbf_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (cmd.wr_byte),
		.waddr (waddr_ext[AW-1:0]),
		.wdata (data_q[7:0]),
		.raddr (raddr_ext[AW-1:0]),
		.rdata (rdata)
	);

	// Ring pointers and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= 4'd8;
			read_pos_q  <= 8'd0;
			write_pos_q <= 8'd0;
		end else if (cfg_we) begin
			size_log2_q <= cfg_data;
			read_pos_q  <= 8'd0;
			write_pos_q <= 8'd0;
		end else if (cmd.rewind) begin
			read_pos_q  <= 8'd0;
			write_pos_q <= 8'd0;
		end else begin
			if (cmd.send_start) begin
				write_pos_q <= (write_pos_q + len_c8) & mask;
			end
			if (cmd.rd_start && op_q != OP_PEEK) begin
				read_pos_q <= (read_pos_q + n_next) & mask;
			end
		end
	end

	// Item fields and address walkers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= in_data.opcode;
			len_q     <= in_data.length;
			data_q    <= in_data.send_data;
			rd_addr_q <= read_pos_q;
		end
		if (cmd.send_start) begin
			wr_addr_q <= write_pos_q;
		end
		if (cmd.wr_byte) begin
			wr_addr_q <= (wr_addr_q + 8'd1) & mask;
			data_q    <= data_q >> 8;
		end
		if (cmd.rd_start) begin
			rd_addr_q <= read_pos_q;
			n_q       <= n_next;
		end
		if (cmd.rd_issue || cmd.pk_issue) begin
			rd_addr_q <= (rd_addr_q + 8'd1) & mask;
		end
		if (cmd.cap_lo) begin
			size_q[7:0] <= rdata;
		end
		if (cmd.cap_hi) begin
			size_q[15:8] <= rdata;
		end
		if (cmd.rd_issue) begin
			cap_slot_q <= slot_q;
		end
	end

	// Byte counters and word packing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= 8'd0;
			slot_q <= '0;
			pend_q <= 1'b0;
			word_q <= '0;
		end else begin
			pend_q <= cmd.rd_issue;
			if (cmd.send_start) begin
				left_q <= len_c8;
			end else if (cmd.rd_start) begin
				left_q <= n_next;
				slot_q <= '0;
				word_q <= '0;
			end else if (cmd.wr_byte || cmd.rd_issue) begin
				left_q <= left_q - 8'd1;
			end
			if (cmd.rd_issue) begin
				slot_q <= slot_q + SW'(1);
			end
			if (pend_q) begin
				word_q[cap_slot_q*8 +: 8] <= rdata;
			end
			if (cmd.emit && cmd.emit_data) begin
				slot_q <= '0;
				word_q <= '0;
			end
		end
	end

	// Count field selection.
	always_comb begin
		case (cmd.cnt_sel)
			CNT_SEND: cnt = len_c8;
			CNT_N:    cnt = n_q;
			CNT_SIZE: cnt = size_q[7:0];
			default:  cnt = 8'd0;
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.status     <= cmd.status;
			out_q.count      <= cnt;
			out_q.data_word  <= cmd.emit_data ? 64'(word_q) : 64'd0;
			out_q.word_bytes <= cmd.emit_data ? 4'(slot_q) : 4'd0;
			out_q.last       <= cmd.emit_data ? (left_q == 8'd0) : 1'b1;
			out_q.fill_level <= fill;
			out_q.free_space <= free_b;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

### design/prbf_ctrl.sv
// Controller state machine of the packet ring byte FIFO.
// Depends on prbf_pkg; drives the datapath through cmd_t and reads sts_t.
module prbf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output prbf_pkg::cmd_t cmd,
	input  prbf_pkg::sts_t sts
);
	import prbf_pkg::*;

	state_t   state_q, state_d;
	status_t  res_st_q, res_st_d;
	cnt_sel_t res_cs_q, res_cs_d;

	// State and latched single-result fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			res_st_q <= ST_OK;
			res_cs_q <= CNT_ZERO;
		end else begin
			state_q  <= state_d;
			res_st_q <= res_st_d;
			res_cs_q <= res_cs_d;
		end
	end

	// Next state.
	always_comb begin
		state_d  = state_q;
		res_st_d = res_st_q;
		res_cs_d = res_cs_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d  = S_EMIT1;
				res_st_d = ST_OK;
				res_cs_d = CNT_ZERO;
				case (sts.op)
					OP_REWIND: ;
					OP_SEND: begin
						if (!sts.room) begin
							res_st_d = ST_NOROOM;
						end else if (!sts.len_zero) begin
							state_d  = S_SEND_WR;
							res_cs_d = CNT_SEND;
						end
					end
					OP_RECV, OP_PEEK: begin
						if (sts.fill_zero) begin
							res_st_d = ST_EMPTY;
						end else if (!sts.n_zero) begin
							state_d = S_RD_ISSUE;
						end
					end
					OP_PKT_CHK, OP_PKT_RECV: begin
						if (sts.fill_lt2) begin
							res_st_d = ST_EMPTY;
						end else begin
							state_d = S_PK_0;
						end
					end
					default: res_st_d = ST_EMPTY;
				endcase
			end
			S_SEND_WR: begin
				if (sts.left_one) begin
					state_d = S_EMIT1;
				end
			end
			S_PK_0: state_d = S_PK_1;
			S_PK_1: state_d = S_PK_2;
			S_PK_2: state_d = S_PK_3;
			S_PK_3: begin
				state_d  = S_EMIT1;
				res_st_d = ST_OK;
				res_cs_d = CNT_ZERO;
				if (sts.size_gt_fill) begin
					res_st_d = ST_EMPTY;
				end else if (sts.op == OP_PKT_CHK) begin
					res_st_d = ST_OK;
				end else if (sts.size_big) begin
					res_st_d = ST_SMALL;
					res_cs_d = CNT_SIZE;
				end else if (!sts.n_zero) begin
					state_d = S_RD_ISSUE;
				end
			end
			S_RD_ISSUE: begin
				if (!sts.can_issue) begin
					state_d = S_RD_EMIT;
				end
			end
			S_RD_EMIT: begin
				if (sts.out_free) begin
					state_d = sts.left_zero ? S_IDLE : S_RD_ISSUE;
				end
			end
			S_EMIT1: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd         = '0;
		cmd.status  = res_st_q;
		cmd.cnt_sel = res_cs_q;
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_DISPATCH: begin
				case (sts.op)
					OP_REWIND: cmd.rewind = 1'b1;
					OP_SEND: cmd.send_start = sts.room && !sts.len_zero;
					OP_RECV, OP_PEEK: cmd.rd_start = !sts.fill_zero;
					default: ;
				endcase
			end
			S_SEND_WR: cmd.wr_byte = 1'b1;
			S_PK_0: cmd.pk_issue = 1'b1;
			S_PK_1: begin
				cmd.pk_issue = 1'b1;
				cmd.cap_lo   = 1'b1;
			end
			S_PK_2: cmd.cap_hi = 1'b1;
			S_PK_3: begin
				cmd.rd_start = !sts.size_gt_fill && sts.op == OP_PKT_RECV
					&& !sts.size_big;
			end
			S_RD_ISSUE: cmd.rd_issue = sts.can_issue;
			S_RD_EMIT: begin
				cmd.emit      = sts.out_free;
				cmd.emit_data = 1'b1;
				cmd.status    = ST_OK;
				cmd.cnt_sel   = CNT_N;
			end
			S_EMIT1: cmd.emit = sts.out_free;
			default: ;
		endcase
	end
endmodule

### design/packet_ring_byte_fifo.sv
// Packet ring byte FIFO top level: request, result and configuration
// channels. Depends on prbf_pkg, the three channel interfaces, prbf_ctrl
// and prbf_dp.
//
// Usage: req carries one command (rewind, send, recv, peek, packet check,
// packet recv). Every command yields one or more transactions on rsp; the
// final one has last set. Read bytes leave packed, up to BYTES_PER_WORD
// per transaction. cfg writes size_log2 and empties the ring; it is always
// ready. The user writes it only while the block is idle; the block
// itself does not enforce this. Timing: the byte store moves one byte per
// cycle while a send is written or a result word is filled. Packet
// operations first fetch the two-byte length prefix. Commands are handled
// one at a time. The result register lets the next command be taken while
// the last result of the previous one waits on rsp. A stalled rsp holds
// the controller until its result register frees.
// Reset empties the ring and sets size_log2 to 8; store contents are
// undefined until written.
module packet_ring_byte_fifo #(
	parameter int unsigned CAPACITY       = 256,
	parameter int unsigned BYTES_PER_WORD = 8
) (
	input logic       clk,
	input logic       arst_n,
	prbf_req_if.sink  req,
	prbf_rsp_if.source rsp,
	prbf_cfg_if.sink  cfg
);
	import prbf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	prbf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	prbf_dp #(
		.CAPACITY       (CAPACITY),
		.BYTES_PER_WORD (BYTES_PER_WORD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (req.data),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (rsp.data)
	);
endmodule

### verif/packet_ring_byte_fifo_tb.sv
// Self-checking testbench for the packet ring byte FIFO.
// Depends on prbf_pkg, the three channel interfaces and packet_ring_byte_fifo.
// A local ring model predicts every result transaction; a checker compares them.
module packet_ring_byte_fifo_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import prbf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	int unsigned cycle_cnt = 0;
	int unsigned error_cnt = 0;

	prbf_req_if req ();
	prbf_rsp_if rsp ();
	prbf_cfg_if cfg ();

	packet_ring_byte_fifo DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	// Ring model state.
	logic [7:0]  ring_bytes [256];
	logic [7:0]  rd_ptr;
	logic [7:0]  wr_ptr;
	logic [3:0]  ring_log2;
	out_item_t   expected_rsp [$];
	bit          rsp_stall_mode = 1'b0;

	// Clock and cycle limit.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [7:0] ring_mask();
		logic [3:0] s;
		s = ring_log2;
		if (s < 1) s = 1;
		if (s > 8) s = 8;
		return 8'((9'd1 << s) - 1);
	endfunction

	function automatic logic [7:0] ring_fill();
		return (wr_ptr - rd_ptr) & ring_mask();
	endfunction

	function automatic logic [7:0] ring_free();
		return (rd_ptr - wr_ptr - 8'd1) & ring_mask();
	endfunction

	function automatic void push_rsp(status_t st, logic [7:0] cnt, logic [63:0] word,
			logic [3:0] nb, logic lst);
		out_item_t o;
		o.status = st;
		o.count = cnt;
		o.data_word = word;
		o.word_bytes = nb;
		o.last = lst;
		o.fill_level = ring_fill();
		o.free_space = ring_free();
		expected_rsp.push_back(o);
	endfunction

	// Reads up to limit bytes and queues the packed result words.
	function automatic void predict_read(int unsigned limit, bit consume);
		int unsigned n;
		int unsigned nb;
		logic [63:0] w;
		logic [7:0] start;
		n = ring_fill();
		start = rd_ptr;
		if (n == 0) begin
			push_rsp(ST_EMPTY, 0, 0, 0, 1'b1);
			return;
		end
		if (n > limit) n = limit;
		if (n > 256) n = 256;
		if (consume) rd_ptr = 8'(rd_ptr + n) & ring_mask();
		if (n == 0) begin
			push_rsp(ST_OK, 0, 0, 0, 1'b1);
			return;
		end
		for (int unsigned i = 0; i < n; i += 8) begin
			nb = (n - i > 8) ? 8 : n - i;
			w = '0;
			for (int unsigned j = 0; j < nb; j++)
				w[8*j +: 8] = ring_bytes[8'(start + i + j) & ring_mask()];
			push_rsp(ST_OK, 8'(n), w, 4'(nb), (i + nb >= n));
		end
	endfunction

	function automatic void predict_ring(in_item_t it);
		int unsigned len;
		int unsigned fill;
		int unsigned pkt_size;
		len = int'(it.length);
		case (it.opcode)
			OP_REWIND: begin
				rd_ptr = 0;
				wr_ptr = 0;
				push_rsp(ST_OK, 0, 0, 0, 1'b1);
			end
			OP_SEND: begin
				if (len > 8) len = 8;
				if (ring_free() < len) begin
					push_rsp(ST_NOROOM, 0, 0, 0, 1'b1);
				end else begin
					for (int unsigned i = 0; i < len; i++)
						ring_bytes[8'(wr_ptr + i) & ring_mask()] = it.send_data[8*i +: 8];
					wr_ptr = 8'(wr_ptr + len) & ring_mask();
					push_rsp(ST_OK, 8'(len), 0, 0, 1'b1);
				end
			end
			OP_RECV: predict_read(len, 1'b1);
			OP_PEEK: predict_read(len, 1'b0);
			OP_PKT_CHK, OP_PKT_RECV: begin
				fill = ring_fill();
				if (fill < 2) begin
					push_rsp(ST_EMPTY, 0, 0, 0, 1'b1);
				end else begin
					pkt_size = int'({ring_bytes[8'(rd_ptr + 1) & ring_mask()],
						ring_bytes[rd_ptr]});
					if (pkt_size > fill) push_rsp(ST_EMPTY, 0, 0, 0, 1'b1);
					else if (it.opcode == OP_PKT_CHK) push_rsp(ST_OK, 0, 0, 0, 1'b1);
					else if (pkt_size > len || pkt_size > 256)
						push_rsp(ST_SMALL, 8'(pkt_size), 0, 0, 1'b1);
					else predict_read(pkt_size, 1'b1);
				end
			end
			default: push_rsp(ST_EMPTY, 0, 0, 0, 1'b1);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		error_cnt++;
	endtask

	// Result checker with its own stall pattern on rsp.ready.
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch("unexpected transaction", rsp.data.data_word, 64'd0);
				end else begin
					out_item_t e;
					e = expected_rsp.pop_front();
					if (rsp.data.status !== e.status)
						report_mismatch("status", 64'(rsp.data.status), 64'(e.status));
					if (rsp.data.count !== e.count)
						report_mismatch("count", 64'(rsp.data.count), 64'(e.count));
					if (rsp.data.data_word !== e.data_word)
						report_mismatch("data_word", rsp.data.data_word, e.data_word);
					if (rsp.data.word_bytes !== e.word_bytes)
						report_mismatch("word_bytes", 64'(rsp.data.word_bytes),
							64'(e.word_bytes));
					if (rsp.data.last !== e.last)
						report_mismatch("last", 64'(rsp.data.last), 64'(e.last));
					if (rsp.data.fill_level !== e.fill_level)
						report_mismatch("fill_level", 64'(rsp.data.fill_level),
							64'(e.fill_level));
					if (rsp.data.free_space !== e.free_space)
						report_mismatch("free_space", 64'(rsp.data.free_space),
							64'(e.free_space));
				end
			end
			if (cycle_cnt % 200 == 0) rsp_stall_mode = $urandom_range(0, 2) != 0;
			rsp.ready <= rsp_stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	int unsigned burst_left;

	// Sends one item, with random gaps between bursts.
	task automatic send_item(logic [2:0] op, logic [7:0] len, logic [63:0] dat);
		in_item_t it;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end
		burst_left--;
		it.opcode = op;
		it.length = len;
		it.send_data = dat;
		req.valid <= 1'b1;
		req.data <= it;
		do @(posedge clk); while (!req.ready);
		predict_ring(it);
		req.valid <= 1'b0;
		// The block cannot take a new command in the cycle after an accept.
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_size(logic [3:0] val);
		wait_drained();
		cfg.valid <= 1'b1;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		ring_log2 = val;
		rd_ptr = 0;
		wr_ptr = 0;
	endtask

	// Writes a length-prefixed packet of pkt_len total bytes.
	task automatic push_packet(int unsigned pkt_len);
		logic [7:0] bytes [$];
		logic [63:0] w;
		int unsigned k;
		bytes.push_back(8'(pkt_len));
		bytes.push_back(8'(pkt_len >> 8));
		for (int unsigned i = 2; i < pkt_len; i++) bytes.push_back(8'($urandom));
		while (bytes.size() > 0) begin
			k = (bytes.size() > 8) ? 8 : bytes.size();
			w = {$urandom, $urandom};
			for (int unsigned j = 0; j < k; j++) w[8*j +: 8] = bytes.pop_front();
			send_item(OP_SEND, 8'(k), w);
		end
	endtask

	task automatic test_directed();
		send_item(OP_RECV, 8, 0);
		send_item(OP_PKT_CHK, 0, 0);
		send_item(OP_SEND, 0, '1);
		send_item(OP_SEND, 255, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_SEND, 8, 64'h0123_4567_89AB_CDEF);
		send_item(OP_PEEK, 0, 0);
		send_item(OP_PEEK, 255, 0);
		send_item(OP_RECV, 3, 0);
		send_item(OP_PKT_CHK, 0, 0);
		send_item(OP_REWIND, 0, 0);
		send_item(3'd6, 0, 0);
		send_item(3'd7, 255, '1);
		send_item(OP_SEND, 2, 64'h0001);
		send_item(OP_PKT_RECV, 0, 0);
		send_item(OP_SEND, 1, 64'h55);
		send_item(OP_PKT_CHK, 0, 0);
		send_item(OP_PKT_RECV, 2, 0);
		push_packet(20);
		send_item(OP_PKT_RECV, 10, 0);
		send_item(OP_PKT_CHK, 0, 0);
		send_item(OP_PKT_RECV, 20, 0);
		send_item(OP_SEND, 2, 64'h0000);
		send_item(OP_PKT_RECV, 0, 0);
		send_item(OP_RECV, 255, 0);
	endtask

	// Small ring: fill until no room, then drain.
	task automatic test_small_ring();
		write_size(4'd1);
		send_item(OP_SEND, 1, 64'hA5);
		send_item(OP_SEND, 1, 64'h5A);
		send_item(OP_PEEK, 255, 0);
		send_item(OP_RECV, 255, 0);
		write_size(4'd0);
		send_item(OP_SEND, 2, 64'h0302);
		send_item(OP_SEND, 1, 64'h77);
		send_item(OP_RECV, 1, 0);
		write_size(4'd3);
		repeat (4) send_item(OP_SEND, 3, {$urandom, $urandom});
		send_item(OP_RECV, 255, 0);
	endtask

	task automatic test_random(int unsigned items);
		int unsigned sel;
		for (int unsigned n = 0; n < items; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 25) push_packet($urandom_range(2, 40));
			else if (sel < 45) send_item(OP_SEND, 8'($urandom_range(0, 10)), {$urandom, $urandom});
			else if (sel < 58) send_item(OP_PKT_RECV, 8'($urandom), 0);
			else if (sel < 66) send_item(OP_PKT_CHK, 8'($urandom), {$urandom, $urandom});
			else if (sel < 78) send_item(OP_RECV, 8'($urandom_range(0, 40)), 0);
			else if (sel < 86) send_item(OP_PEEK, 8'($urandom), 0);
			else if (sel < 90) send_item(OP_RECV, 8'($urandom), 0);
			else if (sel < 94) send_item(OP_REWIND, 8'($urandom), {$urandom, $urandom});
			else send_item(3'($urandom_range(6, 7)), 8'($urandom), 0);
			if (n == items / 2) wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		burst_left = 0;
		ring_log2 = 4'd8;
		rd_ptr = 0;
		wr_ptr = 0;
		foreach (ring_bytes[i]) ring_bytes[i] = 8'h00;
		req.valid = 1'b0;
		req.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_small_ring();
		write_size(4'd15);
		test_random(75);
		write_size(4'd5);
		test_random(37);
		write_size(4'd8);
		test_random(75);
		wait_drained();

		if (error_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

### filelist.f
design/prbf_pkg.sv
design/prbf_req_if.sv
design/prbf_rsp_if.sv
design/prbf_cfg_if.sv
design/prbf_ram.sv
design/prbf_dp.sv
design/prbf_ctrl.sv
design/packet_ring_byte_fifo.sv
verif/packet_ring_byte_fifo_tb.sv
